/* rtl/b64dh_pkg.sv */
`timescale 1ns / 1ps

package b64dh_pkg;

  localparam int unsigned DigestBytesDef = 16;
  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_final;
  } b64dh_in_t;

  typedef struct packed {
    logic [7:0] hex_char;
    logic       decode_ok;
    logic       run_end;
  } b64dh_out_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_HI   = 4'b0100,
    ST_LO   = 4'b1000
  } b64dh_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // apply the decode step for the input transfer
    logic clear_run;  // final character: reset run state
    logic rd_en;      // read digest store
    logic rd_next;    // read at index + 1 and advance
    logic idx_clr;    // rewind read index
    logic load_hi;
    logic load_lo;
    logic load_fail;
  } b64dh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic final_ok;
    logic last_idx;
  } b64dh_status_t;

  // {valid, 6-bit value}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return r;
  endfunction

endpackage

/* rtl/b64dh_ctrl.sv */
`timescale 1ns / 1ps

module b64dh_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_final_i,
  output logic                   in_stall_o,
  input  b64dh_pkg::b64dh_status_t status_i,
  output b64dh_pkg::b64dh_cmd_t    cmd_o
);

  b64dh_pkg::b64dh_state_e state_q, state_d;
  logic can_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b64dh_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a final character may need the output register for the failure result
  assign can_take   = (state_q == b64dh_pkg::ST_IDLE) && (!in_final_i || status_i.out_free);
  assign in_stall_o = !can_take;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      b64dh_pkg::ST_IDLE: begin
        if (in_valid_i && can_take) begin
          cmd_o.accept = 1'b1;
          if (in_final_i) begin
            cmd_o.clear_run = 1'b1;
            if (status_i.final_ok) begin
              cmd_o.idx_clr = 1'b1;
              state_d       = b64dh_pkg::ST_READ;
            end else begin
              cmd_o.load_fail = 1'b1;
            end
          end
        end
      end
      b64dh_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = b64dh_pkg::ST_HI;
      end
      b64dh_pkg::ST_HI: begin
        if (status_i.out_free) begin
          cmd_o.load_hi = 1'b1;
          state_d       = b64dh_pkg::ST_LO;
        end
      end
      b64dh_pkg::ST_LO: begin
        if (status_i.out_free) begin
          cmd_o.load_lo = 1'b1;
          if (status_i.last_idx) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = b64dh_pkg::ST_IDLE;
          end else begin
            // fetch the next byte while the low digit goes out
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_next = 1'b1;
            state_d       = b64dh_pkg::ST_HI;
          end
        end
      end
      default: begin
        state_d = b64dh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/b64dh_datapath.sv */
`timescale 1ns / 1ps

module b64dh_datapath #(
  parameter int unsigned DIGEST_BYTES = b64dh_pkg::DigestBytesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  b64dh_pkg::b64dh_in_t      in_data_i,
  input  b64dh_pkg::b64dh_cmd_t     cmd_i,
  output b64dh_pkg::b64dh_status_t  status_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output b64dh_pkg::b64dh_out_t     out_data_o
);

  localparam int unsigned CntW = $clog2(DIGEST_BYTES + 1);
  localparam int unsigned IdxW = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1;

  logic [13:0]     acc_q;
  logic [2:0]      pend_q;
  logic [CntW-1:0] cnt_q;
  logic            pad_q, err_q;
  logic [7:0]      mem [DIGEST_BYTES];
  logic [7:0]      rd_data_q;
  logic [IdxW-1:0] rd_idx_q, rd_addr;
  b64dh_pkg::b64dh_out_t out_q;
  logic            out_valid_q;

  logic [6:0]      sx;
  logic            active, is_pad, take, bad, byte_done, cnt_full, wr, overflow, nxt_err;
  logic [13:0]     acc_new;
  logic [3:0]      pend_sum;
  logic [7:0]      byte_val;
  logic [CntW-1:0] nxt_cnt;

  // decode step
  assign sx        = b64dh_pkg::sextet_of(in_data_i.char_code);
  assign active    = !pad_q && !err_q;
  assign is_pad    = (in_data_i.char_code == b64dh_pkg::PadChar);
  assign take      = active && !is_pad && sx[6];
  assign bad       = active && !is_pad && !sx[6];
  assign acc_new   = {acc_q[7:0], sx[5:0]};
  assign pend_sum  = {1'b0, pend_q} + 4'd6;
  assign byte_done = pend_sum[3];
  // when a byte completes, pend_sum - 8 is just its low three bits
  assign byte_val  = 8'(acc_new >> pend_sum[2:0]);
  assign cnt_full  = (cnt_q == CntW'(DIGEST_BYTES));
  assign wr        = take && byte_done && !cnt_full;
  assign overflow  = take && byte_done && cnt_full;
  assign nxt_err   = err_q || bad || overflow;
  assign nxt_cnt   = cnt_q + CntW'(wr);

  assign status_o.final_ok = !nxt_err && (nxt_cnt == CntW'(DIGEST_BYTES));
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.last_idx = (rd_idx_q == IdxW'(DIGEST_BYTES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
      pad_q  <= 1'b0;
      err_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      if (cmd_i.clear_run) begin
        acc_q  <= '0;
        pend_q <= '0;
        cnt_q  <= '0;
        pad_q  <= 1'b0;
        err_q  <= 1'b0;
      end else begin
        if (take) begin
          acc_q  <= acc_new;
          pend_q <= pend_sum[2:0];
        end
        if (active && is_pad) begin
          pad_q <= 1'b1;
        end
        cnt_q <= nxt_cnt;
        err_q <= nxt_err;
      end
    end
  end

  assign rd_addr = cmd_i.rd_next ? (rd_idx_q + IdxW'(1)) : rd_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
    end else if (cmd_i.idx_clr) begin
      rd_idx_q <= '0;
    end else if (cmd_i.rd_en) begin
      rd_idx_q <= rd_addr;
    end
  end

  // digest store
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr) begin
      mem[cnt_q[IdxW-1:0]] <= byte_val;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_hi || cmd_i.load_lo || cmd_i.load_fail) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_hi) begin
      out_q <= '{hex_char: b64dh_pkg::hex_digit(rd_data_q[7:4]), decode_ok: 1'b1,
                 run_end: 1'b0};
    end else if (cmd_i.load_lo) begin
      out_q <= '{hex_char: b64dh_pkg::hex_digit(rd_data_q[3:0]), decode_ok: 1'b1,
                 run_end: status_o.last_idx};
    end else if (cmd_i.load_fail) begin
      out_q <= '{hex_char: 8'd0, decode_ok: 1'b0, run_end: 1'b1};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/base64_digest_to_hex_decoder.sv */
`timescale 1ns / 1ps

// Base64 digest decoder with lowercase hex output.
// Input channel: one base64 character per transfer, is_final on the last.
// Characters are taken at one per cycle while the block is idle; non-final
// characters give no result. A '=' ends decoding for the run, a character
// outside the alphabet or one byte too many flags an error.
// On the final character: if exactly DIGEST_BYTES bytes decoded cleanly,
// the block emits 2*DIGEST_BYTES hex characters, high nibble first, with
// run_end on the last; otherwise one failure result (hex_char 0,
// decode_ok 0, run_end 1) loads into the output register the same cycle.
// Digest output: after the final transfer the store read is registered, then
// one character per cycle while the output is free (the next read overlaps
// the low digit); the input stalls until the last character is in the output reg.
// A stalled output register holds its result and pauses emission; a final
// character is held off while the output register cannot take a result.
// Reset clears the run state and the output valid flag; the digest store
// needs no clearing since it is only read after a full run wrote it.
module base64_digest_to_hex_decoder #(
  parameter int unsigned DIGEST_BYTES = b64dh_pkg::DigestBytesDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  b64dh_pkg::b64dh_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output b64dh_pkg::b64dh_out_t out_data_o
);

  b64dh_pkg::b64dh_cmd_t    cmd;
  b64dh_pkg::b64dh_status_t status;

  b64dh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_final_i (in_data_i.is_final),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  b64dh_datapath #(
    .DIGEST_BYTES (DIGEST_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
